// ----- src/tcgr_pkg.sv -----
// Shared constants, register and opcode codes, and the cursor status bundle
// for the text cursor glyph renderer. No dependencies.
package tcgr_pkg;

  localparam int GLYPH_ROWS_DEF  = 16;
  localparam int GLYPH_COUNT_DEF = 256;
  localparam int GLYPH_WIDTH     = 8;

  localparam int POS_W      = 13;
  localparam int COL_W      = 12;
  localparam int CODE_W     = 8;
  localparam int GROW_W     = 4;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Item opcodes; the fourth code is unused and only reported.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_CHAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_LEFT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_RIGHT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_COLUMN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND_COLOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_COLOR = 3'd6;

  // Control characters.
  localparam logic [CODE_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CODE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CODE_W-1:0] CH_RETURN  = 8'h0D;

  // Cursor status handed from the cursor unit to the sequencer.
  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             halted;
    logic             draw;
  } cur_stat_t;

endpackage

// ----- src/tcgr_font_mem.sv -----
// Font store: one write port, one read port, registered read data.
// Depends on tcgr_pkg for the row width.
module tcgr_font_mem #(
  parameter int DEPTH  = tcgr_pkg::GLYPH_ROWS_DEF * tcgr_pkg::GLYPH_COUNT_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [tcgr_pkg::MASK_W-1:0] wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [tcgr_pkg::MASK_W-1:0] rdata
);
  import tcgr_pkg::*;

  logic [MASK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/tcgr_cursor.sv -----
// Configuration registers, and cursor state updated once per accepted item.
// Depends on tcgr_pkg.
module tcgr_cursor #(
  parameter int GLYPH_ROWS = tcgr_pkg::GLYPH_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            accept,
  input  logic [1:0]                      op,
  input  logic [tcgr_pkg::CODE_W-1:0]     code,
  input  logic [tcgr_pkg::COL_W-1:0]      start_x,
  input  logic [tcgr_pkg::COL_W-1:0]      start_y,
  output tcgr_pkg::cur_stat_t             stat
);
  import tcgr_pkg::*;

  localparam int STEP_W = POS_W + 1;

  logic             wrap_enable;
  logic [COL_W-1:0] margin_left;
  logic [COL_W-1:0] margin_right;
  logic [COL_W-1:0] last_column;
  logic [POS_W-1:0] screen_height;

  logic [POS_W-1:0] cursor_x, cursor_x_next;
  logic [POS_W-1:0] cursor_y, cursor_y_next;
  logic [COL_W-1:0] line_start, line_start_next;
  logic [COL_W-1:0] line_end, line_end_next;
  logic             halted, halted_next;

  logic [STEP_W-1:0] y_step;
  logic              below_bottom;
  logic              past_edge;
  logic              is_newline;

  // Color register writes are taken and ignored; colors are not held here.
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_enable   <= 1'b0;
      margin_left   <= '0;
      margin_right  <= '1;
      last_column   <= COL_W'(639);
      screen_height <= POS_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WRAP_ENABLE:   wrap_enable   <= cfg_data[0];
        REG_MARGIN_LEFT:   margin_left   <= cfg_data[COL_W-1:0];
        REG_MARGIN_RIGHT:  margin_right  <= cfg_data[COL_W-1:0];
        REG_LAST_COLUMN:   last_column   <= cfg_data[COL_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[POS_W-1:0];
        REG_FOREGROUND_COLOR, REG_BACKGROUND_COLOR: ;
        default: ;
      endcase
    end
  end

  assign y_step       = {1'b0, cursor_y} + STEP_W'(GLYPH_ROWS);
  assign below_bottom = cursor_y > screen_height;
  assign is_newline   = code == CH_NEWLINE;
  assign past_edge    = (cursor_x > {1'b0, line_end}) || is_newline;

  always_comb begin
    cursor_x_next   = cursor_x;
    cursor_y_next   = cursor_y;
    line_start_next = line_start;
    line_end_next   = line_end;
    halted_next     = halted;
    if (accept) begin
      unique case (op)
        OP_START: begin
          cursor_x_next = {1'b0, start_x};
          cursor_y_next = {1'b0, start_y};
          if (!wrap_enable) begin
            line_start_next = start_x;
          end else if (margin_left > last_column) begin
            line_start_next = '0;
          end else begin
            line_start_next = margin_left;
          end
          if (!wrap_enable || margin_right > last_column) begin
            line_end_next = last_column;
          end else begin
            line_end_next = margin_right;
          end
          halted_next = 1'b0;
        end
        OP_CHAR: begin
          if (!halted) begin
            priority if (code == CH_NUL) begin
              halted_next = 1'b1;
            end else if (below_bottom) begin
              halted_next = 1'b1;
            end else if (past_edge) begin
              // Wrap drops the triggering character.
              if (!wrap_enable || y_step[POS_W]) begin
                halted_next = 1'b1;
              end else begin
                cursor_x_next = {1'b0, line_start};
                cursor_y_next = y_step[POS_W-1:0];
              end
            end else if (code == CH_RETURN) begin
              if (wrap_enable) begin
                cursor_x_next = {1'b0, line_start};
              end
            end else begin
              cursor_x_next = cursor_x + POS_W'(GLYPH_WIDTH);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= '0;
      cursor_y   <= '0;
      line_start <= '0;
      line_end   <= '0;
      halted     <= 1'b1;
    end else begin
      cursor_x   <= cursor_x_next;
      cursor_y   <= cursor_y_next;
      line_start <= line_start_next;
      line_end   <= line_end_next;
      halted     <= halted_next;
    end
  end

  assign stat.x      = cursor_x;
  assign stat.y      = cursor_y;
  assign stat.halted = halted;
  assign stat.draw   = (op == OP_CHAR) && !halted && (code != CH_NUL) && !below_bottom
                       && !past_edge && (code != CH_RETURN);

endmodule

// ----- src/text_cursor_glyph_renderer_core.sv -----
// Text cursor and glyph renderer, top level. Depends on tcgr_pkg, tcgr_font_mem, tcgr_cursor.
// The cursor report of a load, start or non-drawing character passes the state register, then the
// output register; a drawn character gives GLYPH_ROWS rows, then its report.
// Throughput: one word per cycle while drawing and not stalled; the single font read port sets it.
// Reset (rst, synchronous): cursor at 0,0, halted, config at defaults; font store not cleared.
module text_cursor_glyph_renderer_core #(
  parameter int GLYPH_ROWS  = tcgr_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      op,
  input  logic [tcgr_pkg::CODE_W-1:0]     code,
  input  logic [tcgr_pkg::GROW_W-1:0]     glyph_row,
  input  logic [tcgr_pkg::MASK_W-1:0]     font_bits,
  input  logic [tcgr_pkg::COL_W-1:0]      start_x,
  input  logic [tcgr_pkg::COL_W-1:0]      start_y,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            kind,
  output logic [tcgr_pkg::POS_W-1:0]      pos_x,
  output logic [tcgr_pkg::POS_W-1:0]      pos_y,
  output logic [tcgr_pkg::MASK_W-1:0]     row_mask,
  output logic                            stopped,
  output logic                            last,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcgr_pkg::*;

  localparam int DEPTH   = GLYPH_COUNT * GLYPH_ROWS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ROW_W   = $clog2(GLYPH_ROWS);
  localparam int CNT_W   = $clog2(GLYPH_ROWS + 1);
  localparam int CMP_W   = CODE_W + 1;
  localparam int RCMP_W  = CNT_W + GROW_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DRAW   = 3'b010,
    ST_REPORT = 3'b100
  } state_t;

  state_t state, state_next;

  logic      accept;
  cur_stat_t stat;

  logic              code_ok;
  logic              row_ok;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              font_we;

  logic [ADDR_W-1:0] glyph_base;
  logic              blank;
  logic [CNT_W-1:0]  issue_cnt, issue_cnt_next;
  logic [CNT_W-1:0]  emit_cnt, emit_cnt_next;
  logic              data_valid, data_valid_next;
  logic              slot_free;
  logic              move_row;
  logic              issue_rd;
  logic              send_report;
  logic [ADDR_W-1:0] rd_addr;
  logic [MASK_W-1:0] rd_data;

  assign in_stall  = state != ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Font loads are validated against the store geometry; out of range loads drop.
  assign code_ok   = {1'b0, code} < CMP_W'(GLYPH_COUNT);
  assign row_ok    = RCMP_W'(glyph_row) < RCMP_W'(GLYPH_ROWS);
  assign base_addr = ADDR_W'(code) * ADDR_W'(GLYPH_ROWS);
  assign wr_addr   = base_addr + ADDR_W'(glyph_row);
  assign font_we   = accept && (op == OP_LOAD) && code_ok && row_ok;

  // Writes happen only in idle and reads only while drawing, so the two ports
  // never touch the same entry in one cycle.
  assign rd_addr = glyph_base + ADDR_W'(issue_cnt[ROW_W-1:0]);

  tcgr_font_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (wr_addr),
    .wdata (font_bits),
    .re    (issue_rd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  tcgr_cursor #(
    .GLYPH_ROWS (GLYPH_ROWS)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (op),
    .code      (code),
    .start_x   (start_x),
    .start_y   (start_y),
    .stat      (stat)
  );

  // The output register is free when empty or being taken this cycle.
  assign slot_free   = !out_valid || !out_stall;
  // Read data sits in the memory's output register until it moves out.
  assign move_row    = (state == ST_DRAW) && data_valid && slot_free;
  assign issue_rd    = (state == ST_DRAW) && (issue_cnt != CNT_W'(GLYPH_ROWS))
                       && (!data_valid || move_row);
  assign send_report = (state == ST_REPORT) && slot_free;

  always_comb begin
    state_next      = state;
    issue_cnt_next  = issue_cnt;
    emit_cnt_next   = emit_cnt;
    data_valid_next = data_valid;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          issue_cnt_next  = '0;
          emit_cnt_next   = '0;
          data_valid_next = 1'b0;
          state_next      = stat.draw ? ST_DRAW : ST_REPORT;
        end
      end
      ST_DRAW: begin
        if (issue_rd) begin
          issue_cnt_next = issue_cnt + CNT_W'(1);
        end
        if (issue_rd) begin
          data_valid_next = 1'b1;
        end else if (move_row) begin
          data_valid_next = 1'b0;
        end
        if (move_row) begin
          emit_cnt_next = emit_cnt + CNT_W'(1);
          if (emit_cnt == CNT_W'(GLYPH_ROWS - 1)) begin
            state_next = ST_REPORT;
          end
        end
      end
      ST_REPORT: begin
        if (send_report) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      data_valid <= 1'b0;
      issue_cnt  <= '0;
      emit_cnt   <= '0;
    end else begin
      state      <= state_next;
      data_valid <= data_valid_next;
      issue_cnt  <= issue_cnt_next;
      emit_cnt   <= emit_cnt_next;
    end
  end

  // Latch the glyph base and the blank flag for codes beyond the store.
  always_ff @(posedge clk) begin
    if (accept) begin
      glyph_base <= base_addr;
      blank      <= !code_ok;
    end
  end

  // Output register: take a glyph row or the closing report, else drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_row || send_report) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_row) begin
      kind     <= 1'b0;
      pos_x    <= stat.x;
      pos_y    <= stat.y + POS_W'(emit_cnt);
      row_mask <= blank ? '0 : rd_data;
      stopped  <= 1'b0;
      last     <= 1'b0;
    end else if (send_report) begin
      kind     <= 1'b1;
      pos_x    <= stat.x;
      pos_y    <= stat.y;
      row_mask <= '0;
      stopped  <= stat.halted;
      last     <= 1'b1;
    end
  end

endmodule

// ----- src/tcgr_checker.sv -----
// Port-level checks for the text cursor glyph renderer, bound to the top level.
// Depends on tcgr_pkg for port widths.
module tcgr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            kind,
  input logic [tcgr_pkg::POS_W-1:0]      pos_x,
  input logic [tcgr_pkg::POS_W-1:0]      pos_y,
  input logic [tcgr_pkg::MASK_W-1:0]     row_mask,
  input logic                            stopped,
  input logic                            last
);
  import tcgr_pkg::*;

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(pos_y)
      && $stable(row_mask) && $stable(kind) && $stable(last))
    else $error("stalled result word changed");

  // Every report closes its item and only a report does.
  a_last_is_report: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == last))
    else $error("last flag does not match report kind");

  a_row_not_stopped: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> !stopped)
    else $error("glyph row carries stopped flag");

  a_report_no_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> row_mask == '0)
    else $error("cursor report carries glyph bits");

  // One item at a time: an accepted item blocks the input the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after accept");

endmodule

bind text_cursor_glyph_renderer_core tcgr_checker u_tcgr_checker (.*);

// ----- bench/text_cursor_glyph_renderer_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for text_cursor_glyph_renderer_core: a queued item driver, an
// in-house cursor and glyph predictor, and an in-order word checker. Needs tcgr_pkg.
module text_cursor_glyph_renderer_core_tb;
  import tcgr_pkg::*;

  // The fourth opcode has no meaning; the block only reports the cursor for it.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  // Tail wait at the end of the run, covering a drawn character's rows and report.
  localparam int TAIL_CYCLES = GLYPH_ROWS_DEF + 8;
  localparam int FONT_DEPTH = GLYPH_COUNT_DEF * GLYPH_ROWS_DEF;

  typedef struct packed {
    logic [1:0]        op;
    logic [CODE_W-1:0] code;
    logic [GROW_W-1:0] glyph_row;
    logic [MASK_W-1:0] font_bits;
    logic [COL_W-1:0]  start_x;
    logic [COL_W-1:0]  start_y;
  } text_item_t;

  typedef struct packed {
    logic              kind;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [MASK_W-1:0] row_mask;
    logic              stopped;
    logic              last;
  } render_word_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // Block ports; the driven inputs are known from time zero.
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [1:0]            op        = '0;
  logic [CODE_W-1:0]     code      = '0;
  logic [GROW_W-1:0]     glyph_row = '0;
  logic [MASK_W-1:0]     font_bits = '0;
  logic [COL_W-1:0]      start_x   = '0;
  logic [COL_W-1:0]      start_y   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  kind;
  logic [POS_W-1:0]      pos_x;
  logic [POS_W-1:0]      pos_y;
  logic [MASK_W-1:0]     row_mask;
  logic                  stopped;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  text_cursor_glyph_renderer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .code      (code),
    .glyph_row (glyph_row),
    .font_bits (font_bits),
    .start_x   (start_x),
    .start_y   (start_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .row_mask  (row_mask),
    .stopped   (stopped),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stimulus and expectation stores.
  text_item_t   pending_items[$];
  text_item_t   held_item;
  render_word_t expected_words[$];
  render_word_t seen_word;

  // Glyphs whose sixteen rows have all been loaded; only these are ever drawn, so the
  // block never reads a font entry that was not written.
  logic [CODE_W-1:0] drawable_codes[$];
  bit                is_drawable[0:GLYPH_COUNT_DEF-1];

  // Predictor copy of the block: font, cursor, line bounds and the registers it uses.
  logic [MASK_W-1:0] font_shadow[0:FONT_DEPTH-1];
  logic [POS_W-1:0]  cursor_col = '0;
  logic [POS_W-1:0]  cursor_row = '0;
  logic [COL_W-1:0]  line_left  = '0;
  logic [COL_W-1:0]  line_right = '0;
  logic              string_done = 1'b1;
  logic              cfg_wrap   = 1'b0;
  logic [COL_W-1:0]  cfg_left   = '0;
  logic [COL_W-1:0]  cfg_right  = 12'd4095;
  logic [COL_W-1:0]  cfg_last   = 12'd639;
  logic [POS_W-1:0]  cfg_height = 13'd480;

  // Run bookkeeping. steady turns off idling on both sides for a long stretch.
  bit steady = 1'b0;
  int fail_count = 0;
  int accepted_items = 0;
  int glyph_words = 0;
  int cursor_reports = 0;
  int cycle_count = 0;

  // Work out every word one accepted item causes and append it to the expectations.
  task automatic predict_item(input text_item_t it);
    render_word_t     w;
    logic [POS_W:0]   next_row;
    int               r;
    case (it.op)
      OP_LOAD: font_shadow[{it.code, it.glyph_row}] = it.font_bits;
      OP_START: begin
        cursor_col = {1'b0, it.start_x};
        cursor_row = {1'b0, it.start_y};
        // Margins are fixed here; later register writes do not move them.
        if (!cfg_wrap) line_left = it.start_x;
        else if (cfg_left > cfg_last) line_left = '0;
        else line_left = cfg_left;
        if (!cfg_wrap || cfg_right > cfg_last) line_right = cfg_last;
        else line_right = cfg_right;
        string_done = 1'b0;
      end
      OP_CHAR: begin
        if (!string_done) begin
          if (it.code == CH_NUL) begin
            string_done = 1'b1;
          end else if (cursor_row > cfg_height) begin
            string_done = 1'b1;
          end else if (cursor_col > line_right || it.code == CH_NEWLINE) begin
            // Wrap or stop; either way the triggering character is dropped.
            next_row = {1'b0, cursor_row} + (POS_W + 1)'(GLYPH_ROWS_DEF);
            if (!cfg_wrap || next_row[POS_W]) begin
              string_done = 1'b1;
            end else begin
              cursor_col = line_left;
              cursor_row = next_row[POS_W-1:0];
            end
          end else if (it.code == CH_RETURN) begin
            if (cfg_wrap) cursor_col = line_left;
          end else begin
            // Advance first, then emit every glyph row at the new cursor.
            cursor_col = cursor_col + POS_W'(GLYPH_WIDTH);
            for (r = 0; r < GLYPH_ROWS_DEF; r++) begin
              w.kind     = 1'b0;
              w.pos_x    = cursor_col;
              w.pos_y    = cursor_row + r[POS_W-1:0];
              w.row_mask = font_shadow[{it.code, r[GROW_W-1:0]}];
              w.stopped  = 1'b0;
              w.last     = 1'b0;
              expected_words.push_back(w);
            end
          end
        end
      end
      default: ;
    endcase
    // Every item closes with a cursor report.
    w.kind     = 1'b1;
    w.pos_x    = cursor_col;
    w.pos_y    = cursor_row;
    w.row_mask = '0;
    w.stopped  = string_done;
    w.last     = 1'b1;
    expected_words.push_back(w);
  endtask

  // Driver: hold the word while stalled, otherwise advance to the next pending item or idle at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(held_item);
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99, 0) >= 7)) begin
          held_item = pending_items.pop_front();
          op        <= held_item.op;
          code      <= held_item.code;
          glyph_row <= held_item.glyph_row;
          font_bits <= held_item.font_bits;
          start_x   <= held_item.start_x;
          start_y   <= held_item.start_y;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: stall at random, compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(99, 0) < 7);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: kind %0d pos %0d,%0d",
                 kind, pos_x, pos_y);
          fail_count++;
        end else begin
          seen_word = expected_words.pop_front();
          check_field("kind", 32'(seen_word.kind), 32'(kind));
          check_field("pos_x", 32'(seen_word.pos_x), 32'(pos_x));
          check_field("pos_y", 32'(seen_word.pos_y), 32'(pos_y));
          check_field("row_mask", 32'(seen_word.row_mask), 32'(row_mask));
          check_field("stopped", 32'(seen_word.stopped), 32'(stopped));
          check_field("last", 32'(seen_word.last), 32'(last));
          if (seen_word.kind) cursor_reports++;
          else glyph_words++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] op_v, input logic [CODE_W-1:0] code_v,
                            input logic [GROW_W-1:0] row_v, input logic [MASK_W-1:0] bits_v,
                            input logic [COL_W-1:0] x_v, input logic [COL_W-1:0] y_v);
    text_item_t it;
    it.op        = op_v;
    it.code      = code_v;
    it.glyph_row = row_v;
    it.font_bits = bits_v;
    it.start_x   = x_v;
    it.start_y   = y_v;
    pending_items.push_back(it);
  endtask

  // Unused fields of starts and characters carry random noise.
  task automatic queue_char(input logic [CODE_W-1:0] c);
    queue_item(OP_CHAR, c, GROW_W'($urandom), MASK_W'($urandom), COL_W'($urandom),
               COL_W'($urandom));
  endtask

  task automatic queue_start(input logic [COL_W-1:0] x, input logic [COL_W-1:0] y);
    queue_item(OP_START, CODE_W'($urandom), GROW_W'($urandom), MASK_W'($urandom), x, y);
  endtask

  task automatic queue_spare();
    queue_item(OP_SPARE, CODE_W'($urandom), GROW_W'($urandom), MASK_W'($urandom),
               COL_W'($urandom), COL_W'($urandom));
  endtask

  task automatic load_glyph(input logic [CODE_W-1:0] c);
    int r;
    for (r = 0; r < GLYPH_ROWS_DEF; r++)
      queue_item(OP_LOAD, c, r[GROW_W-1:0], MASK_W'($urandom), COL_W'($urandom),
                 COL_W'($urandom));
    if (!is_drawable[c]) begin
      is_drawable[c] = 1'b1;
      drawable_codes.push_back(c);
    end
  endtask

  function automatic logic [CODE_W-1:0] pick_char();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 8) return CH_NEWLINE;
    if (sel < 15) return CH_RETURN;
    if (sel < 18) return CH_NUL;
    return drawable_codes[$urandom_range(drawable_codes.size() - 1, 0)];
  endfunction

  // Start columns: anywhere, near the left, or just short of the right edge.
  function automatic logic [COL_W-1:0] pick_start_x();
    case ($urandom_range(3, 0))
      0: return COL_W'($urandom);
      1: return COL_W'($urandom_range(64, 0));
      default: begin
        if (cfg_last > 24) return cfg_last - COL_W'($urandom_range(24, 0));
        return COL_W'($urandom_range(24, 0));
      end
    endcase
  endfunction

  // Start rows: anywhere, around the bottom of the screen, or near the top.
  function automatic logic [COL_W-1:0] pick_start_y();
    case ($urandom_range(3, 0))
      0: return COL_W'($urandom);
      1: begin
        if (cfg_height > 40) return COL_W'(cfg_height - POS_W'($urandom_range(40, 0)));
        return COL_W'($urandom_range(40, 0));
      end
      default: return COL_W'($urandom_range(200, 0));
    endcase
  endfunction

  // Mostly whole strings with random text; the rest font edits, loose characters
  // and noise.
  task automatic push_random(input int budget);
    int                made;
    int                len;
    int                sel;
    logic [CODE_W-1:0] c;
    made = 0;
    while (made < budget) begin
      sel = $urandom_range(99, 0);
      if (sel < 68) begin
        queue_start(pick_start_x(), pick_start_y());
        len = $urandom_range(12, 2);
        repeat (len) queue_char(pick_char());
        made += len + 1;
      end else if (sel < 78) begin
        // Rewrite a row, usually of a glyph in use; a stray code stays undrawn.
        if ($urandom_range(3, 0) == 0) c = CODE_W'($urandom);
        else c = drawable_codes[$urandom_range(drawable_codes.size() - 1, 0)];
        queue_item(OP_LOAD, c, GROW_W'($urandom), MASK_W'($urandom), COL_W'($urandom),
                   COL_W'($urandom));
        made++;
      end else if (sel < 82) begin
        load_glyph(CODE_W'($urandom));
        made += GLYPH_ROWS_DEF;
      end else if (sel < 92) begin
        len = $urandom_range(3, 1);
        repeat (len) queue_char(pick_char());
        made += len;
      end else if (sel < 96) begin
        queue_spare();
        made++;
      end else begin
        queue_start(pick_start_x(), pick_start_y());
        made++;
      end
    end
  endtask

  // Wait until every queued item went in and every expected word came out.
  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the shadow copy follows at the accepting edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WRAP_ENABLE:   cfg_wrap   = value[0];
      REG_MARGIN_LEFT:   cfg_left   = value[COL_W-1:0];
      REG_MARGIN_RIGHT:  cfg_right  = value[COL_W-1:0];
      REG_LAST_COLUMN:   cfg_last   = value[COL_W-1:0];
      REG_SCREEN_HEIGHT: cfg_height = value[POS_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] wrap,
                                input logic [CFG_DATA_W-1:0] left,
                                input logic [CFG_DATA_W-1:0] right,
                                input logic [CFG_DATA_W-1:0] last_col,
                                input logic [CFG_DATA_W-1:0] height,
                                input logic [CFG_DATA_W-1:0] fg,
                                input logic [CFG_DATA_W-1:0] bg);
    write_reg(REG_WRAP_ENABLE, wrap);
    write_reg(REG_MARGIN_LEFT, left);
    write_reg(REG_MARGIN_RIGHT, right);
    write_reg(REG_LAST_COLUMN, last_col);
    write_reg(REG_SCREEN_HEIGHT, height);
    write_reg(REG_FOREGROUND_COLOR, fg);
    write_reg(REG_BACKGROUND_COLOR, bg);
  endtask

  initial begin
    logic [CODE_W-1:0] font_set[7];
    font_set = '{8'h01, 8'h80, 8'hFF, 8'h7F, 8'h41, 8'h42, 8'h43};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Out of reset the string is halted: a character only gets a stopped report.
    queue_char(8'h41);
    queue_spare();

    // Fill a working font, then pin the mask extremes on one glyph.
    foreach (font_set[i]) load_glyph(font_set[i]);
    queue_item(OP_LOAD, 8'hFF, 4'd0, 8'hFF, '0, '0);
    queue_item(OP_LOAD, 8'hFF, 4'd15, 8'h00, '1, '1);

    // Stop mode at reset settings: draw, ignored return, newline stop, halted char.
    queue_start(12'd0, 12'd0);
    queue_char(8'h01);
    queue_char(8'hFF);
    queue_char(8'h80);
    queue_char(CH_RETURN);
    queue_char(CH_NEWLINE);
    queue_char(8'h41);
    // Far corner: the bottom check comes before the edge check.
    queue_start(12'd4095, 12'd4095);
    queue_char(8'h41);
    // Last cell on the bottom row draws, the next one stops at the edge.
    queue_start(12'd632, 12'd480);
    queue_char(8'h7F);
    queue_char(8'h41);
    queue_start(12'd0, 12'd481);
    queue_char(8'h42);
    // Terminator.
    queue_start(12'd8, 12'd8);
    queue_char(CH_NUL);
    wait_quiet();

    // Wrap mode inside a narrow window.
    apply_settings(1, 16, 200, 639, 480, 24'h12A5C3, 24'h5A0F33);
    @(negedge clk);
    queue_start(12'd190, 12'd0);
    queue_char(8'h41);
    queue_char(8'h42);
    queue_char(8'h43);
    queue_char(CH_RETURN);
    queue_char(8'h41);
    queue_char(CH_RETURN);
    queue_char(CH_NEWLINE);
    wait_quiet();
    // Drop wrap mid-string: the next newline must stop the string.
    write_reg(REG_WRAP_ENABLE, 0);
    @(negedge clk);
    queue_char(CH_NEWLINE);
    queue_char(8'h41);
    wait_quiet();

    // Margins beyond the screen, tallest screen; pause once halfway for a full drain.
    apply_settings(1, 4095, 4095, 639, 4096, 24'hFFFFFF, 24'h000000);
    @(negedge clk);
    push_random(15);
    wait_quiet();
    @(negedge clk);
    push_random(15);
    wait_quiet();

    // One-column screen, one-line height.
    apply_settings(1, 0, 0, 0, 1, 24'h000000, 24'hFFFFFF);
    @(negedge clk);
    push_random(15);
    wait_quiet();

    // Random settings with no idling on either side.
    apply_settings(CFG_DATA_W'($urandom_range(1, 0)), CFG_DATA_W'($urandom_range(700, 0)),
                   CFG_DATA_W'($urandom_range(700, 0)), CFG_DATA_W'($urandom_range(1023, 0)),
                   CFG_DATA_W'($urandom_range(4096, 1)), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom));
    @(negedge clk);
    steady = 1'b1;
    push_random(45);
    wait_quiet();
    steady = 1'b0;

    // Widest screen in stop mode.
    apply_settings(0, CFG_DATA_W'($urandom_range(4095, 0)),
                   CFG_DATA_W'($urandom_range(4095, 0)), 4095, 4096,
                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    @(negedge clk);
    push_random(20);
    wait_quiet();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d items over six register setups: %0d glyph rows, %0d reports.",
             accepted_items, glyph_words, cursor_reports);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
